// ===== sv/dfg_pkg.sv =====
// ----------------------------------------------------------------------------
// dfg_pkg: shared constants, types and table functions
// Register indexes, reset values, queue sizing and the raised-cosine table
// point function used to build the gain table at elaboration.
// ----------------------------------------------------------------------------
package dfg_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_START  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_LENGTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_STEP   = 2'd2;

   localparam logic [31:0] FADE_START_RST  = 32'd65536;
   localparam logic [31:0] FADE_LENGTH_RST = 32'd65536;
   localparam logic [16:0] RAMP_STEP_RST   = 17'd1024;

   // defaults for top-level parameters
   localparam int SAMPLE_WIDTH_DEF      = 24;
   localparam int COS_TABLE_ENTRIES_DEF = 256;

   // gain format
   localparam int GAIN_W = 31;
   localparam logic [GAIN_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // position fields in the request data
   localparam int POS_W = 32;
   localparam int POS_FIELDS_W = 3 * POS_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;

   // result of the fade engine towards the gain unit
   typedef struct packed {
      logic              done;
      logic [GAIN_W-1:0] target;
   } fade_rsp_type;

   // two truncated Taylor term multiplies by u in Q2.30
   function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] u);
      logic [63:0] t;
      t = (term * u) >> 30;
      t = (t * u) >> 30;
      return t;
   endfunction

   // sin(u)^2 in Q1.30, with u = pi*x/2 in Q2.30
   function automatic logic [GAIN_W-1:0] raised_cos_point(input logic [63:0] u);
      logic [63:0] t;
      logic signed [65:0] s;
      logic [63:0] sc;
      logic [63:0] g;
      s = $signed({2'b00, u});
      t = taylor_mul(u, u) / 64'd6;   s = s - $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd20;  s = s + $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd42;  s = s - $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd72;  s = s + $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd110; s = s - $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd156; s = s + $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd210; s = s - $signed({2'b00, t});
      t = taylor_mul(t, u) / 64'd272; s = s + $signed({2'b00, t});
      if (s < 0) begin
         sc = 64'd0;
      end else if (s > $signed({35'd0, Q30_ONE})) begin
         sc = {33'd0, Q30_ONE};
      end else begin
         sc = s[63:0];
      end
      g = (sc * sc + (64'd1 << 29)) >> 30;
      if (g > {33'd0, Q30_ONE}) begin
         g = {33'd0, Q30_ONE};
      end
      return g[GAIN_W-1:0];
   endfunction

endpackage

// ===== sv/dfg_front.sv =====
// ----------------------------------------------------------------------------
// dfg_front: request intake and queue
// Accepts requests, tags each as position or sample and holds them in a
// short queue so the back end can stall on its own.
// ----------------------------------------------------------------------------
module dfg_front #(
   parameter int DATA_W = 120
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,   // mode
   input  logic [DATA_W-1:0] req_tdata,
   output logic              q_valid,
   input  logic              q_pop,
   output logic              q_mode,
   output logic [DATA_W-1:0] q_data
);

   logic [DATA_W-1:0]       data_ff [dfg_pkg::QUEUE_DEPTH];
   logic                    mode_ff [dfg_pkg::QUEUE_DEPTH];
   logic [dfg_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [dfg_pkg::QPTR_W:0]   count_ff;
   logic push, pop;

   assign req_tready = (count_ff != (dfg_pkg::QPTR_W + 1)'(dfg_pkg::QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;
   assign q_mode     = mode_ff[rd_ptr_ff];
   assign q_data     = data_ff[rd_ptr_ff];

   // store request payload
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= req_tdata;
         mode_ff[wr_ptr_ff] <= req_tuser;
      end
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/dfg_fade.sv =====
// ----------------------------------------------------------------------------
// dfg_fade: position to target gain engine
// Squares summed over a shared multiplier, bit-serial square root,
// restoring division by the fade length, then raised-cosine table lookup
// with linear interpolation.
// ----------------------------------------------------------------------------
module dfg_fade #(
   parameter int COS_TABLE_ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [dfg_pkg::POS_W-1:0] pos_x,
   input  logic [dfg_pkg::POS_W-1:0] pos_y,
   input  logic [dfg_pkg::POS_W-1:0] pos_z,
   input  logic [31:0]              fade_start,
   input  logic [31:0]              fade_length,
   output dfg_pkg::fade_rsp_type    fade_rsp
);

   localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
   localparam int XPOS_W = 17 + IDX_W;
   localparam int GW = dfg_pkg::GAIN_W;

   typedef enum logic [2:0] {
      F_IDLE, F_SQ, F_SQRT, F_DIV, F_IDX, F_LOOK, F_INTERP, F_DONE
   } state_type;

   // raised-cosine table built at elaboration
   logic [GW-1:0] cos_tbl [COS_TABLE_ENTRIES + 1];
   for (genvar i = 0; i <= COS_TABLE_ENTRIES; i++) begin : g_tbl
      localparam logic [63:0] U = (dfg_pkg::HALF_PI_Q30 * i) / COS_TABLE_ENTRIES;
      assign cos_tbl[i] = dfg_pkg::raised_cos_point(U);
   end

   state_type     state_ff;
   logic [95:0]   pos_ff;
   logic [1:0]    cnt_ff;
   logic [63:0]   prod_ff, acc_ff;
   logic [63:0]   rem_ff, res_ff, bit_ff;
   logic [32:0]   drem_ff;
   logic [15:0]   quo_ff;
   logic [4:0]    iter_ff;
   logic [16:0]   x_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]   frac_ff;
   logic [GW-1:0] t0_ff, t1_ff;
   logic [46:0]   dprod_ff;
   logic          up_ff;
   logic          done_ff;
   logic [GW-1:0] target_ff;

   logic [31:0]   coord, cmag;
   logic [63:0]   rb_sum;
   logic          rb_ge;
   logic [31:0]   norm, excess;
   logic [32:0]   dshift;
   logic          dge;
   logic [XPOS_W-1:0] xpos;
   logic [XPOS_W-17:0] xidx;
   logic [IDX_W-1:0] idx_p1;
   logic [GW-1:0] dmag, interp;
   logic [GW:0]   interp_w;

   // pick the coordinate to square and take its magnitude
   always_comb begin
      case (cnt_ff)
         2'd0:    coord = pos_ff[31:0];
         2'd1:    coord = pos_ff[63:32];
         default: coord = pos_ff[95:64];
      endcase
      cmag = coord[31] ? (32'd0 - coord) : coord;
   end

   // square-root digit step
   assign rb_sum = res_ff + bit_ff;
   assign rb_ge  = (rem_ff >= rb_sum);
   assign norm   = res_ff[31:0];
   assign excess = norm - fade_start;

   // division step
   assign dshift = {drem_ff[31:0], 1'b0};
   assign dge    = (dshift >= {1'b0, fade_length});

   // table position from the ratio
   assign xpos = XPOS_W'(x_ff) * XPOS_W'(COS_TABLE_ENTRIES);
   assign xidx = xpos[XPOS_W-1:16];
   assign idx_p1 = (idx_ff == IDX_W'(COS_TABLE_ENTRIES)) ? idx_ff : idx_ff + 1'b1;

   // interpolation result
   assign dmag = up_ff ? (t1_ff - t0_ff) : (t0_ff - t1_ff);
   always_comb begin
      if (up_ff) begin
         interp_w = {1'b0, t0_ff} + {1'b0, dprod_ff[46:16]};
      end else begin
         interp_w = {1'b0, t0_ff} - {1'b0, dprod_ff[46:16]};
      end
      interp = (interp_w > {1'b0, dfg_pkg::Q30_ONE}) ? dfg_pkg::Q30_ONE : interp_w[GW-1:0];
   end

   // sequence one position request through all steps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // register a done pulse as the final step completes, alongside the target
         done_ff <= (state_ff == F_DONE) && (cnt_ff != 2'd0);
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  pos_ff   <= {pos_z, pos_y, pos_x};
                  cnt_ff   <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= F_SQ;
               end
            end
            F_SQ: begin
               if (cnt_ff != 2'd3) prod_ff <= cmag * cmag;
               if (cnt_ff != 2'd0) acc_ff <= acc_ff + prod_ff;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 2'd3) begin
                  rem_ff   <= acc_ff + prod_ff;
                  res_ff   <= '0;
                  bit_ff   <= 64'd1 << 62;
                  state_ff <= F_SQRT;
               end
            end
            F_SQRT: begin
               if (rb_ge) begin
                  rem_ff <= rem_ff - rb_sum;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) state_ff <= F_DIV;
               iter_ff <= '0;
            end
            F_DIV: begin
               if (iter_ff == 5'd0) begin
                  // classify the distance first
                  if (norm <= fade_start) begin
                     x_ff     <= '0;
                     state_ff <= F_IDX;
                  end else if (excess >= fade_length) begin
                     x_ff     <= 17'h10000;
                     state_ff <= F_IDX;
                  end else begin
                     drem_ff <= {1'b0, excess};
                     quo_ff  <= '0;
                     iter_ff <= 5'd1;
                  end
               end else begin
                  drem_ff <= dge ? (dshift - {1'b0, fade_length}) : dshift;
                  quo_ff  <= {quo_ff[14:0], dge};
                  iter_ff <= iter_ff + 1'b1;
                  if (iter_ff == 5'd16) begin
                     x_ff     <= {1'b0, quo_ff[14:0], dge};
                     state_ff <= F_IDX;
                  end
               end
            end
            F_IDX: begin
               if (xidx >= (XPOS_W - 16)'(COS_TABLE_ENTRIES)) begin
                  idx_ff  <= IDX_W'(COS_TABLE_ENTRIES);
                  frac_ff <= '0;
               end else begin
                  idx_ff  <= xidx[IDX_W-1:0];
                  frac_ff <= xpos[15:0];
               end
               state_ff <= F_LOOK;
            end
            F_LOOK: begin
               t0_ff    <= cos_tbl[idx_ff];
               t1_ff    <= (frac_ff != '0) ? cos_tbl[idx_p1] : cos_tbl[idx_ff];
               state_ff <= F_INTERP;
            end
            F_INTERP: begin
               up_ff    <= (t1_ff >= t0_ff);
               state_ff <= F_DONE;
            end
            F_DONE: begin
               dprod_ff <= dmag * frac_ff;
               if (cnt_ff == 2'd0) begin
                  cnt_ff <= 2'd1;
               end else begin
                  target_ff <= interp;
                  state_ff  <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign fade_rsp.done   = done_ff;
   assign fade_rsp.target = target_ff;

endmodule

// ===== sv/dfg_gain.sv =====
// ----------------------------------------------------------------------------
// dfg_gain: gain state and sample path
// Takes queued requests in order, hands positions to the fade engine, sets
// the ramp increment, and scales samples into a registered result stage.
// ----------------------------------------------------------------------------
module dfg_gain #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic                    q_mode,
   input  logic [SAMPLE_WIDTH-1:0] q_sample,
   output logic                    q_pop,
   output logic                    fade_go,
   input  dfg_pkg::fade_rsp_type   fade_rsp,
   input  logic [16:0]             ramp_step,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample,
   output logic [dfg_pkg::GAIN_W-1:0] rsp_gain
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int GW = dfg_pkg::GAIN_W;
   localparam logic [SW+1:0] HALF_RANGE = (SW + 2)'(1) << (SW - 1);
   localparam logic [SW+1:0] SMAX = HALF_RANGE - 1'b1;

   typedef enum logic [2:0] {G_IDLE, G_FADE, G_INC, G_INC2, G_SMP, G_OUT} state_type;

   state_type       state_ff;
   logic [GW-1:0]   running_ff, target_ff;
   logic [31:0]     inc_ff;
   logic [SW-1:0]   smag_ff;
   logic            sneg_ff;
   logic [SW+GW-1:0] prod_ff;
   logic [GW-1:0]   dmag_ff;
   logic            dneg_ff;
   logic [47:0]     rprod_ff;
   logic            rsp_valid_ff;
   logic [SW-1:0]   rsp_sample_ff;
   logic [GW-1:0]   rsp_gain_ff;

   logic signed [32:0] gsum;
   logic [GW-1:0]   gstep;
   logic [SW-1:0]   smag;
   logic [SW+GW:0]  rsum;
   logic [SW+1:0]   ymag;
   logic [SW-1:0]   yout;
   logic signed [31:0] dsig;
   logic [31:0]     rmag;
   logic            out_free;

   // step the running gain and clamp to 0..1
   always_comb begin
      gsum = $signed({2'b00, running_ff}) + $signed({inc_ff[31], inc_ff});
      if (gsum < 0) begin
         gstep = '0;
      end else if (gsum > $signed({2'b00, dfg_pkg::Q30_ONE})) begin
         gstep = dfg_pkg::Q30_ONE;
      end else begin
         gstep = gsum[GW-1:0];
      end
   end

   assign smag = q_sample[SW-1] ? (SW'(0) - q_sample) : q_sample;

   // round half away from zero and saturate
   always_comb begin
      rsum = {1'b0, prod_ff} + (SW + GW + 1)'(1 << 29);
      ymag = rsum[SW+GW:30];
      if (sneg_ff) begin
         yout = (ymag >= HALF_RANGE) ? HALF_RANGE[SW-1:0] : SW'((SW + 2)'(0) - ymag);
      end else begin
         yout = (ymag > SMAX) ? SMAX[SW-1:0] : ymag[SW-1:0];
      end
   end

   assign dsig = $signed({1'b0, fade_rsp.target}) - $signed({1'b0, target_ff});
   assign rmag = rprod_ff[47:16];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop   = (state_ff == G_IDLE) && q_valid;
   assign fade_go = q_pop && !q_mode;

   // sequence requests and hold gain state and result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= G_IDLE;
         running_ff   <= '0;
         target_ff    <= '0;
         inc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new response or drop the one taken
         if ((state_ff == G_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            G_IDLE: begin
               if (q_valid) begin
                  if (q_mode) begin
                     running_ff <= gstep;
                     smag_ff    <= smag;
                     sneg_ff    <= q_sample[SW-1];
                     state_ff   <= G_SMP;
                  end else begin
                     state_ff   <= G_FADE;
                  end
               end
            end
            G_FADE: begin
               if (fade_rsp.done) begin
                  running_ff <= target_ff;
                  target_ff  <= fade_rsp.target;
                  dneg_ff    <= dsig[31];
                  dmag_ff    <= dsig[31] ? GW'(32'sd0 - dsig) : dsig[GW-1:0];
                  state_ff   <= G_INC;
               end
            end
            G_INC: begin
               rprod_ff <= dmag_ff * ramp_step;
               state_ff <= G_INC2;
            end
            G_INC2: begin
               inc_ff   <= dneg_ff ? (32'd0 - rmag) : rmag;
               state_ff <= G_IDLE;
            end
            G_SMP: begin
               prod_ff  <= smag_ff * running_ff;
               state_ff <= G_OUT;
            end
            G_OUT: begin
               if (out_free) begin
                  rsp_sample_ff <= yout;
                  rsp_gain_ff   <= running_ff;
                  state_ff      <= G_IDLE;
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_gain   = rsp_gain_ff;

endmodule

// ===== sv/distance_fade_gain_ramp_top.sv =====
// ----------------------------------------------------------------------------
// distance_fade_gain_ramp_top: distance fade-in with ramped gain
// A sample request passes the queue and the back end's idle, multiply and output
// states; the back end takes no new sample until the last one's result is
// registered, paced by the sample multiply and a result register held by stalls.
// A position request occupies the back end while the fade engine runs, set by the
// 32-step square root and, inside the fade region, the 16-step division.
// Synchronous reset clears the queue, the gain state to zero and the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_fade_gain_ramp_top #(
   parameter int SAMPLE_WIDTH      = dfg_pkg::SAMPLE_WIDTH_DEF,
   parameter int COS_TABLE_ENTRIES = dfg_pkg::COS_TABLE_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser,  // mode
   input  logic [((dfg_pkg::POS_FIELDS_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
      // pos_x, pos_y, pos_z, sample_in
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((SAMPLE_WIDTH + dfg_pkg::GAIN_W + 7) / 8) * 8 - 1:0] rsp_tdata,
      // sample_out, gain_used
   // configuration
   input  logic                           csr_we,
   input  logic [dfg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [dfg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int REQ_W = ((dfg_pkg::POS_FIELDS_W + SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((SAMPLE_WIDTH + dfg_pkg::GAIN_W + 7) / 8) * 8;

   logic [31:0] fade_start_ff, fade_length_ff;
   logic [16:0] ramp_step_ff;

   logic              q_valid, q_pop, q_mode, fade_go;
   logic [REQ_W-1:0]  q_data;
   dfg_pkg::fade_rsp_type fade_rsp;
   logic [SAMPLE_WIDTH-1:0]    rsp_sample;
   logic [dfg_pkg::GAIN_W-1:0] rsp_gain;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_start_ff  <= dfg_pkg::FADE_START_RST;
         fade_length_ff <= dfg_pkg::FADE_LENGTH_RST;
         ramp_step_ff   <= dfg_pkg::RAMP_STEP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            dfg_pkg::CSR_FADE_START:  fade_start_ff  <= csr_wdata;
            dfg_pkg::CSR_FADE_LENGTH: fade_length_ff <= csr_wdata;
            dfg_pkg::CSR_RAMP_STEP:   ramp_step_ff   <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   dfg_front #(.DATA_W(REQ_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_mode     (q_mode),
      .q_data     (q_data)
   );

   dfg_fade #(.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_fade (
      .clock       (clock),
      .reset       (reset),
      .start       (fade_go),
      .pos_x       (q_data[31:0]),
      .pos_y       (q_data[63:32]),
      .pos_z       (q_data[95:64]),
      .fade_start  (fade_start_ff),
      .fade_length (fade_length_ff),
      .fade_rsp    (fade_rsp)
   );

   dfg_gain #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_gain (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_mode     (q_mode),
      .q_sample   (q_data[dfg_pkg::POS_FIELDS_W +: SAMPLE_WIDTH]),
      .q_pop      (q_pop),
      .fade_go    (fade_go),
      .fade_rsp   (fade_rsp),
      .ramp_step  (ramp_step_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sample (rsp_sample),
      .rsp_gain   (rsp_gain)
   );

   assign rsp_tdata = RSP_W'({rsp_gain, rsp_sample});

endmodule

// ===== sv/dfg_check.sv =====
// ----------------------------------------------------------------------------
// dfg_check: port-level checks on the fade gain block
// Watches the response channel for stability, gain range, silence at zero gain and reset state.
// ----------------------------------------------------------------------------
module dfg_check #(
   parameter int SAMPLE_WIDTH = dfg_pkg::SAMPLE_WIDTH_DEF,
   parameter int RSP_W = 56
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [dfg_pkg::GAIN_W-1:0] gain_used;
   logic [SAMPLE_WIDTH-1:0]    sample_out;

   assign sample_out = rsp_tdata[SAMPLE_WIDTH-1:0];
   assign gain_used  = rsp_tdata[SAMPLE_WIDTH +: dfg_pkg::GAIN_W];

   // hold a stalled response
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // keep the gain within 0..1
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> gain_used <= dfg_pkg::Q30_ONE)
      else $error("gain out of range");

   // zero gain gives silence
   a_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gain_used == '0 |-> sample_out == '0)
      else $error("output with zero gain");

   // drop any response on reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind distance_fade_gain_ramp_top dfg_check #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH),
   .RSP_W        (RSP_W)
) u_dfg_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb_distance_fade_gain_ramp_top.sv =====
// ----------------------------------------------------------------------------
// tb_distance_fade_gain_ramp_top: self-checking bench for the distance fade
// Drives position and sample requests under several fade and ramp settings,
// predicts every response with an independent fixed-point gain model and
// compares sample and gain field by field, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_distance_fade_gain_ramp_top;

   localparam int SW    = dfg_pkg::SAMPLE_WIDTH_DEF;
   localparam int TABN  = dfg_pkg::COS_TABLE_ENTRIES_DEF;
   localparam int GW    = dfg_pkg::GAIN_W;
   localparam int REQ_W = ((dfg_pkg::POS_FIELDS_W + SW + 7) / 8) * 8;
   localparam int RSP_W = ((SW + GW + 7) / 8) * 8;
   localparam longint ONE_Q30 = 64'd1073741824;

   typedef struct {
      bit [SW-1:0] smp;
      bit [GW-1:0] gain;
   } faded_sample_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we;
   logic [dfg_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [dfg_pkg::CSR_DATA_W-1:0] csr_wdata;

   // gain model state
   bit [31:0] cos_tab [0:TABN];
   bit [31:0] m_fade_start, m_fade_length;
   bit [16:0] m_ramp_step;
   bit [31:0] m_running, m_target;
   longint    m_increment;

   faded_sample_type faded_q [$];
   int errors;
   int n_positions, n_samples, n_checked;
   int burst_left;
   int hold_req;

   distance_fade_gain_ramp_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // mode
      .req_tdata  (req_tdata),   // pos_x, pos_y, pos_z, sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out, gain_used
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // fill the sin^2 table from a truncated Taylor series
   function automatic void fill_cos_tab();
      bit [63:0] u, term, g;
      longint s;
      for (int i = 0; i <= TABN; i++) begin
         u = dfg_pkg::HALF_PI_Q30 * i / TABN;
         term = u;
         s = u;
         for (int k = 1; k <= 8; k++) begin
            term = (term * u) >> 30;
            term = (term * u) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - longint'(term);
            else s = s + longint'(term);
         end
         if (s < 0) s = 0;
         if (s > ONE_Q30) s = ONE_Q30;
         g = (64'(s) * 64'(s) + (64'd1 << 29)) >> 30;
         if (g > ONE_Q30) g = ONE_Q30;
         cos_tab[i] = g[31:0];
      end
   endfunction

   function automatic bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit [63:0] coord_sq(bit [31:0] c);
      longint v;
      bit [63:0] m;
      v = longint'($signed(c));
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   // target gain for a source position under the current fade settings
   function automatic bit [31:0] fade_gain_target(bit [31:0] px, bit [31:0] py,
                                                  bit [31:0] pz);
      bit [63:0] norm, ex, x, p, idx, frac, t0, t1, g;
      norm = root_floor(coord_sq(px) + coord_sq(py) + coord_sq(pz));
      if (norm <= m_fade_start) begin
         x = 0;
      end else begin
         ex = norm - m_fade_start;
         if (ex >= m_fade_length) x = 65536;
         else x = (ex << 16) / m_fade_length;
      end
      p = x * TABN;
      idx = p >> 16;
      frac = p & 64'hFFFF;
      if (idx >= TABN) begin
         idx = TABN;
         frac = 0;
      end
      t0 = cos_tab[idx];
      t1 = (frac != 0) ? cos_tab[idx + 1] : t0;
      if (t1 >= t0) g = t0 + (((t1 - t0) * frac) >> 16);
      else g = t0 - (((t0 - t1) * frac) >> 16);
      if (g > ONE_Q30) g = ONE_Q30;
      return g[31:0];
   endfunction

   // advance the model on one accepted request
   task automatic apply_request(bit mode, bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                                bit [SW-1:0] smp);
      longint diff, s, g, y;
      bit [63:0] mag;
      faded_sample_type fs;
      if (!mode) begin
         m_running = m_target;
         m_target = fade_gain_target(px, py, pz);
         diff = longint'(m_target) - longint'(m_running);
         mag = (diff < 0) ? -diff : diff;
         mag = (mag * m_ramp_step) >> 16;
         m_increment = (diff < 0) ? -longint'(mag) : longint'(mag);
         n_positions++;
      end else begin
         g = longint'(m_running) + m_increment;
         if (g < 0) g = 0;
         if (g > ONE_Q30) g = ONE_Q30;
         m_running = g[31:0];
         s = longint'($signed(smp));
         mag = (s < 0) ? -s : s;
         mag = (mag * 64'(g) + (64'd1 << 29)) >> 30;
         y = (s < 0) ? -longint'(mag) : longint'(mag);
         if (y > (longint'(1) << (SW - 1)) - 1) y = (longint'(1) << (SW - 1)) - 1;
         if (y < -(longint'(1) << (SW - 1))) y = -(longint'(1) << (SW - 1));
         fs.smp = y[SW-1:0];
         fs.gain = m_running[GW-1:0];
         faded_q.push_back(fs);
         n_samples++;
      end
   endtask

   // offer one request and hold it until accepted; gaps fall between bursts
   task automatic send_req(bit mode, bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                           bit [SW-1:0] smp);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {smp, pz, py, px};
      do @(posedge clock); while (!req_tready);
      apply_request(mode, px, py, pz, smp);
   endtask

   task automatic send_sample();
      send_req(1'b1, $urandom, $urandom, $urandom, SW'($urandom));
   endtask

   // coordinate mostly scaled to the fade region, sometimes anywhere
   function automatic bit [31:0] pick_coord();
      bit [63:0] lim, mag;
      if ($urandom_range(0, 3) == 0) return $urandom;
      lim = (64'(m_fade_start) + 64'(m_fade_length)) * 3 / 4;
      if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
      if (lim == 0) lim = 1;
      mag = $urandom_range(0, lim[31:0]);
      return $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
   endfunction

   task automatic send_position();
      send_req(1'b0, pick_coord(), pick_coord(), pick_coord(), SW'($urandom));
   endtask

   // drop valid, wait for every response, then let a position request finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (faded_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [dfg_pkg::CSR_ADDR_W-1:0] idx,
                            logic [dfg_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         dfg_pkg::CSR_FADE_START:  m_fade_start  = val;
         dfg_pkg::CSR_FADE_LENGTH: m_fade_length = val;
         dfg_pkg::CSR_RAMP_STEP:   m_ramp_step   = val[16:0];
         default: ;
      endcase
   endtask

   task automatic set_fade(bit [31:0] fs, bit [31:0] fl, bit [31:0] rs);
      wait_idle();
      write_reg(dfg_pkg::CSR_FADE_START, fs);
      write_reg(dfg_pkg::CSR_FADE_LENGTH, fl);
      write_reg(dfg_pkg::CSR_RAMP_STEP, rs);
   endtask

   // extremes of the coordinates and samples under the reset settings
   task automatic test_directed();
      send_sample();
      send_req(1'b1, 0, 0, 0, SW'(-1));
      send_req(1'b0, 0, 0, 0, '0);
      send_req(1'b1, 0, 0, 0, {1'b0, {(SW-1){1'b1}}});
      send_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      send_req(1'b1, 0, 0, 0, {1'b0, {(SW-1){1'b1}}});
      send_req(1'b1, 0, 0, 0, {1'b1, {(SW-1){1'b0}}});
      send_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
      send_req(1'b1, '1, '1, '1, '0);
      send_req(1'b1, 0, 0, 0, SW'(1));
      send_req(1'b0, 32'd98304, 0, 0, '0);          // halfway through the fade
      send_req(1'b0, 0, 32'hFFFE_8000, 0, '0);
      send_req(1'b1, 0, 0, 0, {1'b1, {(SW-1){1'b0}}});
      send_req(1'b1, 0, 0, 0, SW'(-1));
      send_req(1'b0, 0, 0, 32'd65536, '0);          // exactly at fade start
      send_req(1'b1, 0, 0, 0, {1'b0, {(SW-1){1'b1}}});
      send_req(1'b0, 32'd70000, 32'd20000, 32'hFFFF_0000, '0);
      repeat (4) send_sample();
   endtask

   // well-formed blocks with random content, plus stray requests
   task automatic test_blocks(int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0: begin
               send_position();
               sent++;
            end
            1: begin
               send_sample();
               sent++;
            end
            default: begin
               send_position();
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(2, 30);
               repeat (len) send_sample();
               sent += len + 1;
            end
         endcase
      end
   endtask

   // hold the receiver off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      wait_idle();
      send_position();
      hold_req = 400;
      burst_left = 200;
      repeat (40) send_sample();
      wait_idle();
   endtask

   // pause the sender until every response is in, then carry on
   task automatic test_drain_pause();
      send_position();
      repeat (10) send_sample();
      req_tvalid <= 1'b0;
      while (faded_q.size() > 0) @(posedge clock);
      repeat (10) send_sample();
   endtask

   // receiver: long hold-offs on request, else stall spans of random density
   always @(posedge clock) begin : rsp_stall
      static int hold_left = 0, span = 0, pct = 0;
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (span == 0) begin
         span = $urandom_range(10, 150);
         case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
         endcase
      end
      span--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= pct);
      end
   end

   // compare each accepted response with the oldest expected one
   always @(posedge clock) begin
      faded_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (faded_q.size() == 0) begin
            if (errors < 10) $display("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            want = faded_q.pop_front();
            n_checked++;
            if (rsp_tdata[SW-1:0] !== want.smp
                || rsp_tdata[SW+GW-1:SW] !== want.gain) begin
               if (errors < 10)
                  $display("mismatch: sample exp %h got %h, gain exp %h got %h",
                           want.smp, rsp_tdata[SW-1:0], want.gain,
                           rsp_tdata[SW+GW-1:SW]);
               errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      errors = 0;
      n_positions = 0;
      n_samples = 0;
      n_checked = 0;
      burst_left = 0;
      hold_req = 0;
      fill_cos_tab();
      m_fade_start = dfg_pkg::FADE_START_RST;
      m_fade_length = dfg_pkg::FADE_LENGTH_RST;
      m_ramp_step = dfg_pkg::RAMP_STEP_RST;
      m_running = 0;
      m_target = 0;
      m_increment = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_blocks(250);
      set_fade(0, 1, 65536);
      test_blocks(300);
      test_backpressure();
      set_fade(0, 0, 0);                        // zero length and zero ramp
      test_blocks(200);
      set_fade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      test_blocks(250);
      set_fade($urandom_range(0, 32'h0010_0000), $urandom_range(1, 32'h0010_0000),
               $urandom_range(1, 65536));
      test_blocks(300);
      test_drain_pause();
      set_fade(32'd131072, 32'd327680, 65536);
      test_blocks(300);
      set_fade($urandom, $urandom, $urandom_range(1, 65536));
      test_blocks(250);
      wait_idle();

      $display("covered %0d position and %0d sample requests, %0d responses checked",
               n_positions, n_samples, n_checked);
      $display("fade settings swept incl. zero length, zero ramp and full-scale extremes");
      if (errors == 0 && faded_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dfg_pkg.sv
sv/dfg_front.sv
sv/dfg_fade.sv
sv/dfg_gain.sv
sv/distance_fade_gain_ramp_top.sv
sv/dfg_check.sv
verif/tb_distance_fade_gain_ramp_top.sv
